FILE: hw/rtl/dti_pkg.sv
// Shared constants and types for the decision tree inference block.
`default_nettype none

package dti_pkg;

    localparam int NODE_COUNT    = 1024;
    localparam int FEATURE_COUNT = 16;
    localparam int NODE_AW       = $clog2(NODE_COUNT);
    localparam int FEAT_AW       = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int EMIT_W        = $clog2(FEATURE_COUNT + 1);
    localparam logic [9:0] STEPS_RESET = 10'd1000;

    localparam logic REQ_NODE    = 1'b0;
    localparam logic REQ_FEATURE = 1'b1;

    localparam logic KIND_PRED    = 1'b0;
    localparam logic KIND_CONTRIB = 1'b1;

    // One tree node as held in the split table.
    typedef struct packed {
        logic               leaf;
        logic [9:0]         right;
        logic [9:0]         left;
        logic signed [15:0] cut;
        logic [3:0]         feat;
    } split_entry_t;

    // One stored feature value with its missing flag.
    typedef struct packed {
        logic               missing;
        logic signed [15:0] value;
    } feature_entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dti_if.sv
// Handshake channels of the decision tree inference block.
`default_nettype none

interface dti_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [9:0]         node_slot;
    logic [3:0]         split_feature;
    logic signed [15:0] split_cut;
    logic [9:0]         left_child;
    logic [9:0]         right_child;
    logic signed [31:0] node_mean;
    logic               node_leaf;
    logic [3:0]         feature_slot;
    logic signed [15:0] feature_value;
    logic               feature_missing;
    logic               run_eval;

    modport source (output valid, req_type, node_slot, split_feature, split_cut,
                    left_child, right_child, node_mean, node_leaf, feature_slot,
                    feature_value, feature_missing, run_eval, input ready);
    modport sink (input valid, req_type, node_slot, split_feature, split_cut,
                  left_child, right_child, node_mean, node_leaf, feature_slot,
                  feature_value, feature_missing, run_eval, output ready);
endinterface

interface dti_res_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [3:0]         result_feature;
    logic signed [31:0] result_value;
    logic               last_result;

    modport source (output valid, result_kind, result_feature, result_value,
                    last_result, input ready);
    modport sink (input valid, result_kind, result_feature, result_value,
                  last_result, output ready);
endinterface

interface dti_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dti_tree_mem.sv
// Split table and mean table of the tree, one write port and one read port each.
`default_nettype none

module dti_tree_mem
    import dti_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [NODE_AW-1:0] wr_addr,
    input  wire split_entry_t       wr_split,
    input  wire logic signed [31:0] wr_mean,
    input  wire logic [NODE_AW-1:0] sp_raddr,
    output      split_entry_t       sp_rdata,
    input  wire logic [NODE_AW-1:0] mn_raddr,
    output      logic signed [31:0] mn_rdata
);

    split_entry_t       split_mem [NODE_COUNT];
    logic signed [31:0] mean_mem  [NODE_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            split_mem[wr_addr] <= wr_split;
            mean_mem[wr_addr]  <= wr_mean;
        end
        sp_rdata <= split_mem[sp_raddr];
        mn_rdata <= mean_mem[mn_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/decision_tree_inference_contrib_top.sv
// Top level of the regression tree inference block with feature contributions.
`default_nettype none

// Regression tree inference with per-feature contributions. Items on the req
// channel either write one tree node (req_type 0) or one feature value
// (req_type 1); each write is taken while the block is idle. A feature write
// with run_eval set starts an evaluation: the walk begins at node 0 and takes
// at most max_steps levels, going right when the feature is greater than the
// cut. It stops at a leaf, at a missing feature, at a feature index beyond
// the store, or before a child index beyond the tree. Each level adds the
// change in node mean, saturated to 32 bits, to the contribution of the
// tested feature. The evaluation then sends 17 result items: the prediction
// first, then one contribution per feature, the last one marked. Sequence:
// an evaluation first fetches the root mean, then walks each level as node
// read, test and mean read, difference, and saturating add on the single
// adder, then ends the walk and sends one result item per cycle while
// res.ready is high. The req channel is not ready during an evaluation. The
// node and mean tables are plain memories with no reset; a node or feature
// never written reads as whatever the memory holds. The max_steps register
// is written through cfg; the user is to write it only at idle time, as the
// block itself does not enforce it. It resets to 1000.
module decision_tree_inference_contrib_top
    import dti_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    dti_req_if.sink   req,
    dti_res_if.source res,
    dti_cfg_if.sink   cfg
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_PRED  = 3'd2;
    localparam logic [2:0] ST_LOOP  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_DIFF  = 3'd5;
    localparam logic [2:0] ST_ACC   = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [9:0]         max_steps_reg;
    logic [9:0]         steps_reg;
    logic [NODE_AW-1:0] node_reg;
    logic [NODE_AW-1:0] child_reg;
    logic [FEAT_AW-1:0] feat_reg;
    logic signed [31:0] pred_reg;
    logic signed [32:0] diff_reg;
    logic [EMIT_W-1:0]  emit_reg;

    feature_entry_t     feat_store [FEATURE_COUNT];
    logic signed [31:0] acc_reg [FEATURE_COUNT];
    logic [FEATURE_COUNT-1:0] acc_valid_reg;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [3:0]         out_feat_reg;
    logic signed [31:0] out_value_reg;
    logic               out_last_reg;

    logic               req_accept;
    logic               node_wr;
    logic               feat_wr;
    logic               eval_start;
    split_entry_t       wr_split;
    split_entry_t       sp_rdata;
    logic signed [31:0] mn_rdata;
    logic [NODE_AW-1:0] mn_raddr;

    feature_entry_t     feat_rd;
    logic               feat_in_range;
    logic [9:0]         child_sel;
    logic               child_in_range;
    logic               walk_stop;

    logic [FEAT_AW-1:0] acc_idx;
    logic signed [31:0] acc_cur;
    logic signed [33:0] acc_sum;
    logic signed [31:0] acc_sat;

    logic               out_load;
    logic               emit_last;
    logic signed [31:0] emit_value;

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_accept = req.valid && req.ready;
    assign node_wr    = req_accept && (req.req_type == REQ_NODE)
                        && (int'(req.node_slot) < NODE_COUNT);
    assign feat_wr    = req_accept && (req.req_type == REQ_FEATURE)
                        && (int'(req.feature_slot) < FEATURE_COUNT);
    assign eval_start = req_accept && (req.req_type == REQ_FEATURE) && req.run_eval;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        wr_split.leaf  = req.node_leaf;
        wr_split.right = req.right_child;
        wr_split.left  = req.left_child;
        wr_split.cut   = req.split_cut;
        wr_split.feat  = req.split_feature;
    end

    // The root mean is fetched at the start; later reads fetch the chosen child.
    assign mn_raddr = (state_reg == ST_CHECK) ? NODE_AW'(child_sel) : '0;

    dti_tree_mem u_mem (
        .clk      (clk),
        .wr_en    (node_wr),
        .wr_addr  (NODE_AW'(req.node_slot)),
        .wr_split (wr_split),
        .wr_mean  (req.node_mean),
        .sp_raddr (node_reg),
        .sp_rdata (sp_rdata),
        .mn_raddr (mn_raddr),
        .mn_rdata (mn_rdata)
    );

    // Node test: the split entry read in the previous cycle is checked here.
    assign feat_in_range  = (int'(sp_rdata.feat) < FEATURE_COUNT);
    assign feat_rd        = feat_store[FEAT_AW'(sp_rdata.feat)];
    assign child_sel      = (feat_rd.value > sp_rdata.cut) ? sp_rdata.right : sp_rdata.left;
    assign child_in_range = (int'(child_sel) < NODE_COUNT);
    assign walk_stop      = sp_rdata.leaf || !feat_in_range || feat_rd.missing
                            || !child_in_range;

    // One read port on the contribution registers, shared by the walk and
    // the result stream. Entries not yet touched in this evaluation read zero.
    assign acc_idx = (state_reg == ST_EMIT) ? FEAT_AW'(emit_reg - EMIT_W'(1)) : feat_reg;
    assign acc_cur = acc_valid_reg[acc_idx] ? acc_reg[acc_idx] : 32'sd0;
    assign acc_sum = 34'(acc_cur) + 34'(diff_reg);

    always_comb
    begin
        if ((acc_sum[33:31] == 3'b000) || (acc_sum[33:31] == 3'b111))
        begin
            acc_sat = acc_sum[31:0];
        end
        else if (acc_sum[33])
        begin
            acc_sat = 32'sh8000_0000;
        end
        else
        begin
            acc_sat = 32'sh7FFF_FFFF;
        end
    end

    assign emit_last  = (int'(emit_reg) == FEATURE_COUNT);
    assign emit_value = (emit_reg == '0) ? pred_reg : acc_cur;
    assign out_load   = (state_reg == ST_EMIT) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (eval_start)
                begin
                    state_next = ST_START;
                end
            end
            ST_START: state_next = ST_PRED;
            ST_PRED:  state_next = ST_LOOP;
            ST_LOOP:
            begin
                state_next = (steps_reg < max_steps_reg) ? ST_CHECK : ST_EMIT;
            end
            ST_CHECK:
            begin
                state_next = walk_stop ? ST_EMIT : ST_DIFF;
            end
            ST_DIFF:  state_next = ST_ACC;
            ST_ACC:   state_next = ST_LOOP;
            ST_EMIT:
            begin
                if (out_load && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_steps_reg <= STEPS_RESET;
            acc_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                max_steps_reg <= cfg.data;
            end
            if (state_reg == ST_START)
            begin
                acc_valid_reg <= '0;
            end
            else if (state_reg == ST_ACC)
            begin
                acc_valid_reg[feat_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (feat_wr)
        begin
            feat_store[FEAT_AW'(req.feature_slot)] <= {req.feature_missing, req.feature_value};
        end
        unique case (state_reg)
            ST_START:
            begin
                node_reg  <= '0;
                steps_reg <= '0;
                emit_reg  <= '0;
            end
            ST_PRED:
            begin
                pred_reg <= mn_rdata;
            end
            ST_CHECK:
            begin
                child_reg <= NODE_AW'(child_sel);
                feat_reg  <= FEAT_AW'(sp_rdata.feat);
            end
            ST_DIFF:
            begin
                diff_reg <= 33'(mn_rdata) - 33'(pred_reg);
                pred_reg <= mn_rdata;
                node_reg <= child_reg;
            end
            ST_ACC:
            begin
                acc_reg[feat_reg] <= acc_sat;
                steps_reg         <= steps_reg + 10'd1;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    emit_reg <= emit_reg + EMIT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_kind_reg  <= (emit_reg == '0) ? KIND_PRED : KIND_CONTRIB;
            out_feat_reg  <= (emit_reg == '0) ? 4'd0 : 4'(emit_reg - EMIT_W'(1));
            out_value_reg <= emit_value;
            out_last_reg  <= emit_last;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.result_kind    = out_kind_reg;
    assign res.result_feature = out_feat_reg;
    assign res.result_value   = out_value_reg;
    assign res.last_result    = out_last_reg;

endmodule

`default_nettype wire
